// ----- rtl/fha_pkg.sv -----
// Package for the first-fit heap allocator: request and result structs,
// status and operation codes, defaults and the shared unit's operation type.
// No dependencies.
package fha_pkg;

  localparam int HEAP_BYTES_DEF    = 32768;
  localparam int GRANULE_BYTES_DEF = 8;

  localparam logic [15:0] STEP_RESET = 16'd8192;
  localparam logic [16:0] LIMIT_MAX  = 17'h1FFFF;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] size_bytes;
    logic [14:0] free_offset;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] address;
    logic [14:0] used_total;
    logic [16:0] usage_limit;
    logic        pressure;
  } out_res_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ----- rtl/fha_mem.sv -----
// Region header memory: one write port, one registered read port.
// Entry zero reads as the initial whole-heap region until first written.
// No dependencies.
module fha_mem #(
  parameter int XW = 12,
  parameter int DW = 26,
  parameter logic [DW-1:0] INIT0 = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [XW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [XW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**XW];
  logic [DW-1:0] rd_r;
  logic          valid0_r;
  logic          sel0_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
      sel0_r   <= 1'b0;
    end else begin
      if (we && (waddr == '0)) begin
        valid0_r <= 1'b1;
      end
      sel0_r <= (raddr == '0) && !valid0_r;
    end
  end

  assign rdata = sel0_r ? INIT0 : rd_r;

endmodule

// ----- rtl/fha_alu.sv -----
// Shared add/subtract unit that steps the soft usage limit.
// Depends on fha_pkg.
module fha_alu import fha_pkg::*; #(
  parameter int W = 19
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res
);

  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
  end

endmodule

// ----- rtl/first_fit_heap_allocator_unit.sv -----
// Top level of the first-fit heap allocator: sequencer over the header memory.
// Depends on fha_pkg, fha_mem and fha_alu.
//
// One request at a time, and the receiver cannot stall the result: each result
// is shown for exactly one cycle on out_valid. A zero-size request, an allocate
// on an empty list and a free that fails its range checks answer in the cycle
// after acceptance without raising busy. Otherwise busy is high from acceptance
// until the result cycle. An allocate walks the free regions from the list
// head in S_A_READ, relinks in S_A_LINK unless the region taken is the head,
// then raises the limit by the configured step in S_GROW; a failed allocate
// answers after its walk. A free walks from the search hint or the list head,
// one region per cycle of the header memory's single read port, then reads
// the next region, checks and links (S_F_NREAD, S_F_DECIDE, S_F_WBLK), then
// lowers the limit by the configured step in S_SHRINK. The header memory
// needs no clearing pass after reset. HEAP_BYTES and GRANULE_BYTES must be
// powers of two; the block itself does not check this.
module first_fit_heap_allocator_unit import fha_pkg::*; #(
  parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
  parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int GL         = $clog2(GRANULE_BYTES);
  localparam int GRAN_COUNT = HEAP_BYTES / GRANULE_BYTES;
  localparam int XW         = $clog2(GRAN_COUNT);
  localparam int PW         = XW + 1;
  localparam int GW         = 17 - GL;
  localparam int SW         = ((PW > 15) ? PW : 15) + 1;
  localparam int HL         = $clog2(HEAP_BYTES);
  localparam int UW         = HL;
  localparam int AW         = ((HL > 17) ? HL : 17) + 2;

  localparam logic [PW-1:0] LIST_END = PW'(GRAN_COUNT);
  localparam logic [SW-1:0] END_S    = SW'(GRAN_COUNT);
  localparam logic [SW-1:0] AREA_S   = SW'(GRAN_COUNT - 1);
  localparam logic [2*PW-1:0] INIT0  = {PW'(GRAN_COUNT - 1), PW'(GRAN_COUNT)};

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_READ,
    S_A_LINK,
    S_F_WALK,
    S_F_NREAD,
    S_F_DECIDE,
    S_F_WBLK,
    S_GROW,
    S_SHRINK
  } state_t;

  state_t          state_r, state_nxt;
  logic            func_r, func_nxt;
  logic [GW-1:0]   g_r, g_nxt;
  logic [PW-1:0]   blk_r, blk_nxt;
  logic [PW-1:0]   prev_r, prev_nxt;
  logic [PW-1:0]   psize_r, psize_nxt;
  logic [PW-1:0]   cur_r, cur_nxt;
  logic [PW-1:0]   nptr_r, nptr_nxt;
  logic [PW-1:0]   nsize_r, nsize_nxt;
  logic [PW-1:0]   nnext_r, nnext_nxt;
  logic [PW-1:0]   link_r, link_nxt;
  logic [2*PW-1:0] wbuf_r, wbuf_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   hint_r, hint_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic [16:0]     lim_r, lim_nxt;
  logic [15:0]     step_r;
  logic [1:0]      status_r, status_nxt;
  logic [14:0]     addr_r, addr_nxt;
  logic            press_r, press_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            we;
  logic [XW-1:0]   waddr;
  logic [2*PW-1:0] wdata;
  logic [XW-1:0]   raddr;
  logic [2*PW-1:0] rdata;
  logic [PW-1:0]   rd_size;
  logic [PW-1:0]   rd_next;

  alu_op_t         alu_op;
  logic [AW-1:0]   alu_a;
  logic [AW-1:0]   alu_b;
  logic [AW-1:0]   alu_res;

  fha_mem #(
    .XW    (XW),
    .DW    (2 * PW),
    .INIT0 (INIT0)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  fha_alu #(
    .W (AW)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign rd_size = rdata[2*PW-1:PW];
  assign rd_next = rdata[PW-1:0];

  always_comb begin
    logic [16:0]   rsum;
    logic [GW-1:0] g_in;
    logic [14:0]   blk_w;
    logic          free_bad;
    logic [AW-1:0] gbytes;
    logic [SW-1:0] rem;
    logic [PW-1:0] link;
    logic          mergep;
    logic          mergen;
    logic [PW-1:0] b;
    logic [SW-1:0] bsize;
    logic [SW-1:0] bsize_f;
    logic [PW-1:0] bnext;

    rsum     = {1'b0, in_req.size_bytes} + 17'(GRANULE_BYTES - 1);
    g_in     = GW'(rsum >> GL);
    blk_w    = in_req.free_offset >> GL;
    free_bad = (in_req.free_offset[GL-1:0] != '0) ||
               (SW'(blk_w) >= AREA_S) ||
               (SW'(g_in) > (AREA_S - SW'(blk_w))) ||
               ((AW'(g_in) << GL) > AW'(used_r));
    gbytes   = AW'(g_r) << GL;
    rem      = SW'(cur_r) + SW'(g_r);
    link     = rd_next;
    mergep   = (prev_r != LIST_END) && ((SW'(prev_r) + SW'(psize_r)) == SW'(blk_r));
    b        = mergep ? prev_r : blk_r;
    bsize    = mergep ? (SW'(psize_r) + SW'(g_r)) : SW'(g_r);
    mergen   = (nptr_r != LIST_END) && ((SW'(b) + bsize) == SW'(nptr_r));
    bsize_f  = mergen ? (bsize + SW'(nsize_r)) : bsize;
    bnext    = mergen ? nnext_r : nptr_r;

    state_nxt     = state_r;
    func_nxt      = func_r;
    g_nxt         = g_r;
    blk_nxt       = blk_r;
    prev_nxt      = prev_r;
    psize_nxt     = psize_r;
    cur_nxt       = cur_r;
    nptr_nxt      = nptr_r;
    nsize_nxt     = nsize_r;
    nnext_nxt     = nnext_r;
    link_nxt      = link_r;
    wbuf_nxt      = wbuf_r;
    head_nxt      = head_r;
    hint_nxt      = hint_r;
    used_nxt      = used_r;
    lim_nxt       = lim_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    press_nxt     = press_r;
    out_valid_nxt = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    alu_op        = ALU_ADD;
    alu_a         = AW'(lim_r);
    alu_b         = AW'(step_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_req.func;
          g_nxt     = g_in;
          addr_nxt  = '0;
          press_nxt = 1'b0;
          if (in_req.size_bytes == '0) begin
            status_nxt    = ST_ZERO;
            out_valid_nxt = 1'b1;
          end else if (in_req.func == FUNC_ALLOC) begin
            press_nxt = (AW'(used_r) + AW'(in_req.size_bytes)) >= AW'(lim_r);
            prev_nxt  = LIST_END;
            if (head_r == LIST_END) begin
              status_nxt    = ST_FAIL;
              out_valid_nxt = 1'b1;
            end else begin
              cur_nxt   = head_r;
              raddr     = head_r[XW-1:0];
              state_nxt = S_A_READ;
            end
          end else if (free_bad) begin
            status_nxt    = ST_FAIL;
            out_valid_nxt = 1'b1;
          end else begin
            blk_nxt = PW'(blk_w);
            if ((hint_r != LIST_END) && (SW'(blk_w) > SW'(hint_r))) begin
              prev_nxt  = hint_r;
              raddr     = hint_r[XW-1:0];
              state_nxt = S_F_WALK;
            end else if ((head_r == LIST_END) || (SW'(head_r) >= SW'(blk_w))) begin
              prev_nxt = LIST_END;
              nptr_nxt = head_r;
              if (head_r == LIST_END) begin
                state_nxt = S_F_DECIDE;
              end else begin
                raddr     = head_r[XW-1:0];
                state_nxt = S_F_NREAD;
              end
            end else begin
              prev_nxt  = head_r;
              raddr     = head_r[XW-1:0];
              state_nxt = S_F_WALK;
            end
          end
        end
      end

      S_A_READ: begin
        if (SW'(rd_size) >= SW'(g_r)) begin
          if ((SW'(rd_size) > SW'(g_r)) && (rem >= END_S)) begin
            status_nxt    = ST_FAIL;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            if (SW'(rd_size) > SW'(g_r)) begin
              we    = 1'b1;
              waddr = rem[XW-1:0];
              wdata = {PW'(SW'(rd_size) - SW'(g_r)), rd_next};
              link  = PW'(rem);
            end
            used_nxt = used_r + UW'(gbytes);
            addr_nxt = 15'(AW'(cur_r) << GL);
            hint_nxt = prev_r;
            if (prev_r == LIST_END) begin
              head_nxt  = link;
              state_nxt = S_GROW;
            end else begin
              link_nxt  = link;
              state_nxt = S_A_LINK;
            end
          end
        end else begin
          prev_nxt  = cur_r;
          psize_nxt = rd_size;
          cur_nxt   = rd_next;
          if (rd_next == LIST_END) begin
            status_nxt    = ST_FAIL;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            raddr = rd_next[XW-1:0];
          end
        end
      end

      S_A_LINK: begin
        we        = 1'b1;
        waddr     = prev_r[XW-1:0];
        wdata     = {psize_r, link_r};
        state_nxt = S_GROW;
      end

      S_F_WALK: begin
        psize_nxt = rd_size;
        if (rd_next == LIST_END) begin
          nptr_nxt  = LIST_END;
          state_nxt = S_F_DECIDE;
        end else if (SW'(rd_next) >= SW'(blk_r)) begin
          nptr_nxt  = rd_next;
          raddr     = rd_next[XW-1:0];
          state_nxt = S_F_NREAD;
        end else begin
          prev_nxt = rd_next;
          raddr    = rd_next[XW-1:0];
        end
      end

      S_F_NREAD: begin
        nsize_nxt = rd_size;
        nnext_nxt = rd_next;
        state_nxt = S_F_DECIDE;
      end

      S_F_DECIDE: begin
        if (((prev_r != LIST_END) && ((SW'(prev_r) + SW'(psize_r)) > SW'(blk_r))) ||
            ((nptr_r != LIST_END) && ((SW'(blk_r) + SW'(g_r)) > SW'(nptr_r)))) begin
          status_nxt    = ST_FAIL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          hint_nxt  = prev_r;
          used_nxt  = used_r - UW'(gbytes);
          state_nxt = S_SHRINK;
          if (mergep || (prev_r == LIST_END)) begin
            if (!mergep) begin
              head_nxt = blk_r;
            end
            we    = 1'b1;
            waddr = b[XW-1:0];
            wdata = {PW'(bsize_f), bnext};
          end else begin
            we        = 1'b1;
            waddr     = prev_r[XW-1:0];
            wdata     = {psize_r, blk_r};
            wbuf_nxt  = {PW'(bsize_f), bnext};
            state_nxt = S_F_WBLK;
          end
        end
      end

      S_F_WBLK: begin
        we        = 1'b1;
        waddr     = blk_r[XW-1:0];
        wdata     = wbuf_r;
        state_nxt = S_SHRINK;
      end

      S_GROW: begin
        alu_op = ALU_ADD;
        if ((step_r == '0) || (AW'(used_r) < AW'(lim_r))) begin
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (alu_res > AW'(LIMIT_MAX)) begin
          lim_nxt       = LIMIT_MAX;
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          lim_nxt = 17'(alu_res);
        end
      end

      S_SHRINK: begin
        alu_op = ALU_SUB;
        if ((step_r == '0) || alu_res[AW-1] || (alu_res < AW'(used_r))) begin
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          lim_nxt = 17'(alu_res);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      hint_r      <= LIST_END;
      used_r      <= '0;
      lim_r       <= 17'(STEP_RESET);
      step_r      <= STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      hint_r      <= hint_nxt;
      used_r      <= used_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        step_r <= cfg_data;
      end
    end
    func_r   <= func_nxt;
    g_r      <= g_nxt;
    blk_r    <= blk_nxt;
    prev_r   <= prev_nxt;
    psize_r  <= psize_nxt;
    cur_r    <= cur_nxt;
    nptr_r   <= nptr_nxt;
    nsize_r  <= nsize_nxt;
    nnext_r  <= nnext_nxt;
    link_r   <= link_nxt;
    wbuf_r   <= wbuf_nxt;
    status_r <= status_nxt;
    addr_r   <= addr_nxt;
    press_r  <= press_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  assign out_res.status      = status_r;
  assign out_res.address     = addr_r;
  assign out_res.used_total  = 15'(used_r);
  assign out_res.usage_limit = lim_r;
  assign out_res.pressure    = press_r;

  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither in progress nor answered");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.address[GL-1:0] == '0))
    else $error("address not granule aligned");

  a_limit_above: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == ST_OK) && (func_r == FUNC_ALLOC) && (step_r != '0))
    |-> (AW'(used_r) < AW'(lim_r)))
    else $error("limit not above usage after allocation");

endmodule
